// File: rtl/scm_pkg.sv
// Shared types and constants for the stereo correlation meter.
// Used by scm_ctrl, scm_datapath and the stereo_correlation_meter top level.
package scm_pkg;

	// Field widths fixed by the port list
	localparam int PORT_W    = 16;
	localparam int MAX_SB    = 24;
	localparam int DECAY_W   = 24;
	localparam int SUM_W     = 48;
	localparam int REG_IDX_W = 1;

	// Request codes
	typedef enum logic [1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_TICK   = 2'd1,
		REQ_CLEAR  = 2'd2
	} req_t;

	// Configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_METER_ENABLE = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_DECAY_COEFF  = 1'd1;

	// Reset value of the decay coefficient, Q0.24
	localparam logic [DECAY_W-1:0] DECAY_RESET = 24'd16776051;

	// Datapath operations, one per cycle
	typedef enum logic [4:0] {
		OP_NONE,
		OP_WRITE,
		OP_TICK_INIT,
		OP_POW_MUL,
		OP_POW_UPD,
		OP_DEC_LO,
		OP_DEC_HI,
		OP_DEC_WR,
		OP_WALK_INIT,
		OP_WALK_RD,
		OP_WALK_LR,
		OP_WALK_LL,
		OP_WALK_RR,
		OP_WALK_ACC,
		OP_NORM_LOAD,
		OP_NORM_SHIFT,
		OP_SQ_MUL,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_NUM_MUL,
		OP_DIV_INIT,
		OP_DIV_TEST,
		OP_DIV_STEP,
		OP_FINISH
	} dp_op_t;

	// Controller states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_POW_MUL,
		ST_POW_UPD,
		ST_DEC_LO,
		ST_DEC_HI,
		ST_DEC_WR,
		ST_WALK_INIT,
		ST_WALK_RD,
		ST_WALK_LR,
		ST_WALK_LL,
		ST_WALK_RR,
		ST_WALK_ACC,
		ST_NORM_LOAD,
		ST_NORM,
		ST_SQ_MUL,
		ST_SQRT_INIT,
		ST_SQRT_STEP,
		ST_NUM_MUL,
		ST_DIV_INIT,
		ST_DIV_TEST,
		ST_DIV_STEP,
		ST_FINISH
	} ctrl_state_t;

	// Command from controller to datapath
	typedef struct packed {
		logic   clear;
		dp_op_t op;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic cnt_zero;
		logic sel_last;
		logic xy_zero;
		logic need_shift;
		logic it_zero;
		logic div_over;
	} dp_sts_t;

endpackage

// File: rtl/scm_ctrl.sv
// Controller state machine of the stereo correlation meter.
// Depends on scm_pkg; drives scm_datapath through dp_cmd_t and reads dp_sts_t.
module scm_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       req_type,
	output logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             cfg_we,
	input  logic [scm_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic                             cfg_enable_bit,
	output logic                             enable,
	input  scm_pkg::dp_sts_t                 sts,
	output scm_pkg::dp_cmd_t                 cmd
);
	import scm_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        en_q;
	logic        out_valid_q;
	logic        accept;
	logic        out_free;
	logic        cfg_rise;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_rise = cfg_we && (cfg_index == REG_METER_ENABLE) && !en_q && cfg_enable_bit;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign enable    = en_q;

	// State, enable and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			en_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && (cfg_index == REG_METER_ENABLE)) begin
				en_q <= cfg_enable_bit;
			end
			if (cmd.op == OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath command
	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_NONE;
		cmd.clear = cfg_rise || (accept && (req_type == REQ_CLEAR));
		unique case (state_q)
			ST_IDLE: begin
				if (accept && en_q) begin
					if (req_type == REQ_SAMPLE) begin
						cmd.op = OP_WRITE;
					end else if (req_type == REQ_TICK) begin
						cmd.op  = OP_TICK_INIT;
						state_d = ST_POW_MUL;
					end
				end
			end
			ST_POW_MUL: begin
				if (sts.cnt_zero) begin
					state_d = ST_DEC_LO;
				end else begin
					cmd.op  = OP_POW_MUL;
					state_d = ST_POW_UPD;
				end
			end
			ST_POW_UPD: begin
				cmd.op  = OP_POW_UPD;
				state_d = ST_POW_MUL;
			end
			ST_DEC_LO: begin
				cmd.op  = OP_DEC_LO;
				state_d = ST_DEC_HI;
			end
			ST_DEC_HI: begin
				cmd.op  = OP_DEC_HI;
				state_d = ST_DEC_WR;
			end
			ST_DEC_WR: begin
				cmd.op  = OP_DEC_WR;
				state_d = sts.sel_last ? ST_WALK_INIT : ST_DEC_LO;
			end
			ST_WALK_INIT: begin
				cmd.op  = OP_WALK_INIT;
				state_d = ST_WALK_RD;
			end
			ST_WALK_RD: begin
				if (sts.cnt_zero) begin
					state_d = ST_NORM_LOAD;
				end else begin
					cmd.op  = OP_WALK_RD;
					state_d = ST_WALK_LR;
				end
			end
			ST_WALK_LR: begin
				cmd.op  = OP_WALK_LR;
				state_d = ST_WALK_LL;
			end
			ST_WALK_LL: begin
				cmd.op  = OP_WALK_LL;
				state_d = ST_WALK_RR;
			end
			ST_WALK_RR: begin
				cmd.op  = OP_WALK_RR;
				state_d = ST_WALK_ACC;
			end
			ST_WALK_ACC: begin
				cmd.op  = OP_WALK_ACC;
				state_d = ST_WALK_RD;
			end
			ST_NORM_LOAD: begin
				cmd.op  = OP_NORM_LOAD;
				state_d = ST_NORM;
			end
			ST_NORM: begin
				priority if (sts.xy_zero) begin
					state_d = ST_FINISH;
				end else if (sts.need_shift) begin
					cmd.op = OP_NORM_SHIFT;
				end else begin
					state_d = ST_SQ_MUL;
				end
			end
			ST_SQ_MUL: begin
				cmd.op  = OP_SQ_MUL;
				state_d = ST_SQRT_INIT;
			end
			ST_SQRT_INIT: begin
				cmd.op  = OP_SQRT_INIT;
				state_d = ST_SQRT_STEP;
			end
			ST_SQRT_STEP: begin
				cmd.op = OP_SQRT_STEP;
				if (sts.it_zero) begin
					state_d = ST_NUM_MUL;
				end
			end
			ST_NUM_MUL: begin
				cmd.op  = OP_NUM_MUL;
				state_d = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.op  = OP_DIV_INIT;
				state_d = ST_DIV_TEST;
			end
			ST_DIV_TEST: begin
				cmd.op  = OP_DIV_TEST;
				state_d = sts.div_over ? ST_FINISH : ST_DIV_STEP;
			end
			ST_DIV_STEP: begin
				cmd.op = OP_DIV_STEP;
				if (sts.it_zero) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.op  = OP_FINISH;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: rtl/scm_datapath.sv
// Datapath of the stereo correlation meter: history memory, shared multiplier,
// running sums, square root and divide iterations, output word. Uses scm_pkg.
module scm_datapath #(
	parameter int HISTORY_DEPTH = 512,
	parameter int SAMPLE_BITS   = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  scm_pkg::dp_cmd_t                       cmd,
	output scm_pkg::dp_sts_t                       sts,
	input  logic signed [scm_pkg::PORT_W-1:0]      left_sample,
	input  logic signed [scm_pkg::PORT_W-1:0]      right_sample,
	input  logic                                   right_valid,
	input  logic                                   cfg_we,
	input  logic [scm_pkg::REG_IDX_W-1:0]          cfg_index,
	input  logic [scm_pkg::DECAY_W-1:0]            cfg_data,
	output logic signed [scm_pkg::PORT_W-1:0]      correlation_now,
	output logic signed [scm_pkg::PORT_W-1:0]      correlation_shown
);
	import scm_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int SB = SAMPLE_BITS;
	localparam logic signed [48:0] SUM_MAX = 49'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [48:0] SUM_MIN = -49'sh0_8000_0000_0000;

	// Saturating accumulate of a product into a 48-bit sum
	function automatic logic [SUM_W-1:0] sat_acc(logic [SUM_W-1:0] s, logic [63:0] p,
			logic allow_neg);
		logic signed [48:0] t;
		t = signed'({s[SUM_W-1], s}) + signed'(p[48:0]);
		if (t > SUM_MAX) begin
			t = SUM_MAX;
		end else if (allow_neg && (t < SUM_MIN)) begin
			t = SUM_MIN;
		end else if (!allow_neg && (t < 0)) begin
			t = '0;
		end
		return t[SUM_W-1:0];
	endfunction

	logic [2*SB-1:0]       mem [HISTORY_DEPTH];
	logic [2*SB-1:0]       rd_q;
	logic [AW-1:0]         wr_idx_q;
	logic [AW-1:0]         pos_q;
	logic [CW-1:0]         pend_q;
	logic [CW-1:0]         n_q;
	logic [CW-1:0]         cnt_q;
	logic [DECAY_W-1:0]    decay_q;
	logic [24:0]           p_q;
	logic [24:0]           rnd_q;
	logic [1:0]            sel_q;
	logic [SUM_W-1:0]      sum_q [3];
	logic signed [63:0]    prod_q;
	logic signed [31:0]    mul_a;
	logic signed [31:0]    mul_b;
	logic [SUM_W-1:0]      x_q;
	logic [SUM_W-1:0]      y_q;
	logic [SUM_W-1:0]      a_q;
	logic                  a_neg_q;
	logic [63:0]           rad_q;
	logic [63:0]           res_q;
	logic [4:0]            it_q;
	logic [46:0]           rem_q;
	logic [14:0]           q_q;
	logic signed [15:0]    disp_q;
	logic signed [15:0]    now_q;
	logic signed [15:0]    shown_q;

	logic [MAX_SB-1:0]     l_ext;
	logic [MAX_SB-1:0]     r_ext;
	logic [2*SB-1:0]       wr_word;
	logic [CW:0]           start_t;
	logic [AW-1:0]         start_pos;
	logic [AW-1:0]         pos_next;
	logic [SUM_W-1:0]      cur;
	logic [SUM_W-1:0]      mag;
	logic [48:0]           dec_r;
	logic [SUM_W-1:0]      dec_val;
	logic signed [SB-1:0]  rd_l;
	logic signed [SB-1:0]  rd_r;
	logic [63:0]           sq_bit;
	logic [63:0]           sq_trial;
	logic [46:0]           div_sh;
	logic signed [15:0]    cv;
	logic signed [16:0]    diff;

	// Build the stored word; a mono word copies left to right
	assign l_ext   = {{(MAX_SB-PORT_W){1'b0}}, left_sample};
	assign r_ext   = right_valid ? {{(MAX_SB-PORT_W){1'b0}}, right_sample} : l_ext;
	assign wr_word = {l_ext[SB-1:0], r_ext[SB-1:0]};

	// Oldest pending entry and ring advance
	assign start_t   = (CW+1)'(wr_idx_q) + (CW+1)'(HISTORY_DEPTH) - (CW+1)'(pend_q);
	assign start_pos = (start_t >= (CW+1)'(HISTORY_DEPTH)) ?
			AW'(start_t - (CW+1)'(HISTORY_DEPTH)) : AW'(start_t);
	assign pos_next  = (pos_q == AW'(HISTORY_DEPTH - 1)) ? '0 : pos_q + 1'b1;

	// Decay of the selected sum by magnitude and sign
	assign cur     = sum_q[sel_q];
	assign mag     = cur[SUM_W-1] ? SUM_W'(-cur) : cur;
	assign dec_r   = prod_q[48:0] + 49'(rnd_q);
	assign dec_val = cur[SUM_W-1] ? SUM_W'(-dec_r) : SUM_W'(dec_r);

	assign rd_l = rd_q[2*SB-1:SB];
	assign rd_r = rd_q[SB-1:0];

	assign sq_bit   = 64'(1) << {it_q, 1'b0};
	assign sq_trial = res_q + sq_bit;
	assign div_sh   = 47'(res_q) << it_q;

	assign cv   = a_neg_q ? -signed'({1'b0, q_q}) : signed'({1'b0, q_q});
	assign diff = 17'(cv) - 17'(disp_q);

	// Status back to the controller
	assign sts.cnt_zero   = (cnt_q == '0);
	assign sts.sel_last   = (sel_q == 2'd2);
	assign sts.xy_zero    = (x_q == '0) || (y_q == '0);
	assign sts.need_shift = (|x_q[SUM_W-1:31]) || (|y_q[SUM_W-1:31]) || (|a_q[SUM_W-1:31]);
	assign sts.it_zero    = (it_q == '0);
	assign sts.div_over   = (rem_q >= (47'(res_q) << 15));

	assign correlation_now   = now_q;
	assign correlation_shown = shown_q;

	// Select multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_POW_MUL: begin
				mul_a = 32'(p_q);
				mul_b = 32'(decay_q);
			end
			OP_DEC_LO: begin
				mul_a = 32'(mag[23:0]);
				mul_b = 32'(p_q);
			end
			OP_DEC_HI: begin
				mul_a = 32'(mag[47:24]);
				mul_b = 32'(p_q);
			end
			OP_WALK_LR: begin
				mul_a = 32'(rd_l);
				mul_b = 32'(rd_r);
			end
			OP_WALK_LL: begin
				mul_a = 32'(rd_l);
				mul_b = 32'(rd_l);
			end
			OP_WALK_RR: begin
				mul_a = 32'(rd_r);
				mul_b = 32'(rd_r);
			end
			OP_SQ_MUL: begin
				mul_a = signed'(x_q[31:0]);
				mul_b = signed'(y_q[31:0]);
			end
			OP_NUM_MUL: begin
				mul_a = 32'sd32767;
				mul_b = signed'(a_q[31:0]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// History ring: write on sample words, registered read during the walk
	always_ff @(posedge clk) begin
		if (cmd.op == OP_WRITE) begin
			mem[wr_idx_q] <= wr_word;
		end
		if (cmd.op == OP_WALK_RD) begin
			rd_q <= mem[pos_q];
		end
	end

	// Shared multiplier register and working registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (cmd.op)
			OP_TICK_INIT: begin
				n_q   <= pend_q;
				cnt_q <= pend_q;
				pos_q <= start_pos;
				p_q   <= 25'h100_0000;
				sel_q <= '0;
			end
			OP_POW_UPD: begin
				p_q   <= 25'((prod_q + 64'sd8388608) >>> 24);
				cnt_q <= cnt_q - 1'b1;
			end
			OP_DEC_HI: rnd_q <= 25'((prod_q + 64'sd8388608) >>> 24);
			OP_DEC_WR: sel_q <= sel_q + 1'b1;
			OP_WALK_INIT: cnt_q <= n_q;
			OP_WALK_RD: begin
				pos_q <= pos_next;
				cnt_q <= cnt_q - 1'b1;
			end
			OP_NORM_LOAD: begin
				x_q     <= sum_q[1];
				y_q     <= sum_q[2];
				a_q     <= sum_q[0][SUM_W-1] ? SUM_W'(-sum_q[0]) : sum_q[0];
				a_neg_q <= sum_q[0][SUM_W-1];
				q_q     <= '0;
			end
			OP_NORM_SHIFT: begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				a_q <= a_q >> 1;
			end
			OP_SQRT_INIT: begin
				rad_q <= prod_q;
				res_q <= '0;
				it_q  <= 5'd30;
			end
			OP_SQRT_STEP: begin
				if (rad_q >= sq_trial) begin
					rad_q <= rad_q - sq_trial;
					res_q <= (res_q >> 1) + sq_bit;
				end else begin
					res_q <= res_q >> 1;
				end
				it_q <= it_q - 1'b1;
			end
			OP_DIV_INIT: begin
				rem_q <= prod_q[46:0];
				it_q  <= 5'd14;
			end
			OP_DIV_TEST: begin
				if (sts.div_over) begin
					q_q <= 15'h7FFF;
				end
			end
			OP_DIV_STEP: begin
				if (rem_q >= div_sh) begin
					rem_q         <= rem_q - div_sh;
					q_q[it_q[3:0]] <= 1'b1;
				end
				it_q <= it_q - 1'b1;
			end
			OP_FINISH: begin
				now_q   <= cv;
				shown_q <= disp_q + 16'(diff >>> 2);
			end
			default: begin
			end
		endcase
	end

	// Control state: ring pointer, pending count, sums, display, decay register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			pend_q   <= '0;
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			sum_q[2] <= '0;
			disp_q   <= '0;
			decay_q  <= DECAY_RESET;
		end else begin
			if (cfg_we && (cfg_index == REG_DECAY_COEFF)) begin
				decay_q <= cfg_data;
			end
			if (cmd.clear) begin
				pend_q   <= '0;
				sum_q[0] <= '0;
				sum_q[1] <= '0;
				sum_q[2] <= '0;
				disp_q   <= '0;
			end else begin
				unique case (cmd.op)
					OP_WRITE: begin
						wr_idx_q <= (wr_idx_q == AW'(HISTORY_DEPTH - 1)) ? '0 :
								wr_idx_q + 1'b1;
						if (pend_q != CW'(HISTORY_DEPTH)) begin
							pend_q <= pend_q + 1'b1;
						end
					end
					OP_TICK_INIT: pend_q <= '0;
					OP_DEC_WR: sum_q[sel_q] <= dec_val;
					OP_WALK_LL: sum_q[0] <= sat_acc(sum_q[0], prod_q, 1'b1);
					OP_WALK_RR: sum_q[1] <= sat_acc(sum_q[1], prod_q, 1'b0);
					OP_WALK_ACC: sum_q[2] <= sat_acc(sum_q[2], prod_q, 1'b0);
					OP_FINISH: disp_q <= disp_q + 16'(diff >>> 2);
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// File: rtl/stereo_correlation_meter.sv
// Top level of the stereo correlation meter.
// Depends on scm_pkg, scm_ctrl and scm_datapath.
//
// Usage:
//   Input words (in_valid/in_stall) carry a request: a sample pair, a tick or a
//   clear. A sample pair is written into the history ring; a mono pair copies left to right.
//   A tick walks the n pending samples (n at most HISTORY_DEPTH) and returns one
//   output word (out_valid/out_stall) with the instant and smoothed correlation.
//   A tick steps the decay power once per pending sample, decays the three sums
//   and walks the pending entries on the one shared 32x32 multiplier, then runs the
//   normalize shifts, then up to 31 square root steps and 15 divide steps.
//   in_stall is high while a tick is in progress; a sample or clear never raises
//   it. A finished result sits in the output register; samples keep flowing
//   while it waits, and the next tick holds in its last step until that word is
//   taken.
//   Reset clears the sums, pending count, smoothed value and out_valid, disables
//   the meter and loads the default decay; history is undefined until written.
//   Configuration writes (cfg_we) land at once; enabling the meter clears it.
module stereo_correlation_meter #(
	parameter int HISTORY_DEPTH = 512,
	parameter int SAMPLE_BITS   = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            req_type,
	input  logic signed [scm_pkg::PORT_W-1:0]     left_sample,
	input  logic signed [scm_pkg::PORT_W-1:0]     right_sample,
	input  logic                                  right_valid,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [scm_pkg::PORT_W-1:0]     correlation_now,
	output logic signed [scm_pkg::PORT_W-1:0]     correlation_shown,
	input  logic                                  cfg_we,
	input  logic [scm_pkg::REG_IDX_W-1:0]         cfg_index,
	input  logic [scm_pkg::DECAY_W-1:0]           cfg_data
);
	import scm_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    enable;

	scm_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_enable_bit (cfg_data[0]),
		.enable         (enable),
		.sts            (sts),
		.cmd            (cmd)
	);

	scm_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.left_sample       (left_sample),
		.right_sample      (right_sample),
		.right_valid       (right_valid),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.correlation_now   (correlation_now),
		.correlation_shown (correlation_shown)
	);

	// A finished tick never overwrites a word still waiting at the output
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FINISH) |-> (!out_valid || !out_stall))
		else $error("result written over a waiting output word");

	// An enabled tick holds off further input words
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && enable && (req_type == REQ_TICK)) |=> in_stall)
		else $error("tick accepted without holding input");

	// The correlation stays within plus and minus full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (correlation_now != 16'sh8000) && (correlation_shown != 16'sh8000))
		else $error("correlation out of range");

endmodule

// File: bench/testbench.sv
// Self-checking bench for stereo_correlation_meter: random requests, idling on both sides.
// Depends on scm_pkg and the stereo_correlation_meter RTL; results are checked against
// a bit-accurate predictor of the meter kept in a small scoreboard class.

class meter_scoreboard;
	// predictor state
	logic signed [15:0] hist_l [512];
	logic signed [15:0] hist_r [512];
	int unsigned        wr_idx;
	int unsigned        pend;
	longint             acc_lr, acc_ll, acc_rr;
	int                 corr_now, corr_disp;
	bit                 enabled;
	longint unsigned    decay;
	// expected output words
	logic [15:0]        exp_now [$];
	logic [15:0]        exp_shown [$];
	int                 errors, words_checked, ticks, samples;

	function void reset_state();
		wr_idx = 0; enabled = 0; decay = 16776051;
		clear_sums();
	endfunction

	function void clear_sums();
		pend = 0; acc_lr = 0; acc_ll = 0; acc_rr = 0; corr_now = 0; corr_disp = 0;
	endfunction

	function void write_reg(logic idx, logic [23:0] val);
		if (idx == scm_pkg::REG_METER_ENABLE) begin
			if (!enabled && val[0]) clear_sums();
			enabled = val[0];
		end else begin
			decay = val;
		end
	endfunction

	function longint sat_sum(longint s, longint v, longint lo);
		longint r;
		r = s + v;
		if (r > 64'sh7FFFFFFFFFFF) return 64'sh7FFFFFFFFFFF;
		if (r < lo) return lo;
		return r;
	endfunction

	function longint scale_sum(longint s, longint unsigned p);
		longint unsigned m, r;
		m = (s < 0) ? longint'(-s) : s;
		r = (m >> 24) * p + (((m & 64'hFFFFFF) * p + 64'h800000) >> 24);
		return (s < 0) ? -longint'(r) : longint'(r);
	endfunction

	function longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0; b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b; res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function int phase_corr();
		longint unsigned x, y, a, r, q;
		bit neg;
		x = acc_ll; y = acc_rr; neg = acc_lr < 0;
		a = neg ? longint'(-acc_lr) : acc_lr;
		if (x == 0 || y == 0) return 0;
		while (x >= (64'd1 << 31) || y >= (64'd1 << 31) || a >= (64'd1 << 31)) begin
			x >>= 1; y >>= 1; a >>= 1;
		end
		if (x == 0 || y == 0) return 0;
		r = floor_sqrt(x * y);
		if (r == 0) return 0;
		q = (32767 * a) / r;
		if (q > 32767) q = 32767;
		return neg ? -int'(q) : int'(q);
	endfunction

	// note an accepted input word
	function void note_word(scm_pkg::req_t req, logic signed [15:0] l, logic signed [15:0] r,
			bit rv);
		longint unsigned p;
		longint a, b;
		int unsigned pos;
		int d;
		if (req == scm_pkg::REQ_CLEAR) begin
			clear_sums();
		end else if (req == scm_pkg::REQ_SAMPLE && enabled) begin
			hist_l[wr_idx] = l;
			hist_r[wr_idx] = rv ? r : l;
			wr_idx = (wr_idx + 1) % 512;
			if (pend < 512) pend++;
			samples++;
		end else if (req == scm_pkg::REQ_TICK && enabled) begin
			p = 64'd1 << 24;
			for (int i = 0; i < pend; i++) p = (p * decay + 64'h800000) >> 24;
			acc_lr = scale_sum(acc_lr, p);
			acc_ll = scale_sum(acc_ll, p);
			acc_rr = scale_sum(acc_rr, p);
			pos = (wr_idx + 512 - pend) % 512;
			for (int i = 0; i < pend; i++) begin
				a = hist_l[pos]; b = hist_r[pos];
				acc_lr = sat_sum(acc_lr, a * b, -64'sh800000000000);
				acc_ll = sat_sum(acc_ll, a * a, 0);
				acc_rr = sat_sum(acc_rr, b * b, 0);
				pos = (pos + 1) % 512;
			end
			pend = 0;
			corr_now = phase_corr();
			d = corr_now - corr_disp;
			corr_disp += (d >= 0) ? (d >>> 2) : -((-d + 3) >>> 2);
			exp_now.push_back(corr_now[15:0]);
			exp_shown.push_back(corr_disp[15:0]);
			ticks++;
		end
	endfunction

	// check one output word against the oldest expectation
	function void check_word(logic [15:0] now_v, logic [15:0] shown_v);
		logic [15:0] en, es;
		if (exp_now.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected output word now=%0d shown=%0d",
				$signed(now_v), $signed(shown_v));
			return;
		end
		en = exp_now.pop_front();
		es = exp_shown.pop_front();
		words_checked++;
		if (en !== now_v || es !== shown_v) begin
			errors++;
			if (errors <= 10) $display("mismatch word %0d: now exp %0d got %0d, shown exp %0d got %0d",
				words_checked, $signed(en), $signed(now_v), $signed(es), $signed(shown_v));
		end
	endfunction
endclass

module testbench;
	import scm_pkg::*;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              in_valid = 0;
	logic              in_stall;
	logic [1:0]        req_type = REQ_SAMPLE;
	logic signed [15:0] left_sample = 0, right_sample = 0;
	logic              right_valid = 0;
	logic              out_valid;
	logic              out_stall = 0;
	logic signed [15:0] correlation_now, correlation_shown;
	logic              cfg_we = 0;
	logic [REG_IDX_W-1:0] cfg_index = REG_METER_ENABLE;
	logic [DECAY_W-1:0] cfg_data = 0;

	meter_scoreboard sb;
	bit              rx_quiet;

	stereo_correlation_meter uut (.*);

	always #5 clk = ~clk;

	// take output words, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(correlation_now, correlation_shown);
	end
	initial begin
		int w;
		wait (arst_n);
		forever begin
			w = rx_quiet ? 0 : $urandom_range(0, 12);
			if ($urandom_range(0, 3) == 0) w = 0;
			out_stall <= (w != 0);
			repeat (w) @(posedge clk);
			out_stall <= 0;
			@(posedge clk);
		end
	end

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [23:0] val);
		in_valid <= 0;
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		cfg_we <= 0;
	endtask

	// drive one word, hold until accepted
	task automatic send_word(logic [1:0] req, logic signed [15:0] l, logic signed [15:0] r,
			bit rv, bit gaps);
		int w;
		w = gaps ? $urandom_range(0, 12) : 0;
		if (w > 0) begin
			in_valid <= 0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1; req_type <= req; left_sample <= l; right_sample <= r; right_valid <= rv;
		do @(posedge clk); while (in_stall);
		sb.note_word(req_t'(req), l, r, rv);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.exp_now.size() != 0) @(posedge clk);
		// a tick whose result never comes can still be busy: allow the longest walk
		repeat (3700) @(posedge clk);
	endtask

	task automatic random_burst(int count, bit gaps);
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 80)
				send_word(REQ_SAMPLE, 16'($urandom), 16'($urandom),
					$urandom_range(0, 3) != 0, gaps);
			else if (kind < 92)
				send_word(REQ_TICK, 0, 0, 0, gaps);
			else if (kind < 96)
				send_word(REQ_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom), gaps);
			else
				send_word(2'd3, 16'($urandom), 16'($urandom), 1'($urandom), gaps);
		end
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		rx_quiet = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// disabled: samples and ticks dropped, clear still clears, unknown ignored
		send_word(REQ_SAMPLE, 16'sh7FFF, 16'sh8000, 1, 0);
		send_word(REQ_TICK, 0, 0, 0, 0);
		send_word(REQ_CLEAR, 0, 0, 0, 0);
		send_word(2'd3, 0, 0, 1, 0);
		write_reg(REG_METER_ENABLE, 1);
		// empty tick, zero energy
		send_word(REQ_TICK, 0, 0, 0, 1);
		send_word(REQ_SAMPLE, 0, 0, 1, 0);
		send_word(REQ_TICK, 0, 0, 0, 0);
		// full-scale extremes, mono and anti-phase
		send_word(REQ_SAMPLE, 16'sh7FFF, 16'sh8000, 1, 0);
		send_word(REQ_SAMPLE, 16'sh8000, 16'sh7FFF, 1, 0);
		send_word(REQ_SAMPLE, 16'sh8000, 16'sh1234, 0, 0);
		send_word(REQ_TICK, 0, 0, 0, 0);
		send_word(REQ_SAMPLE, 16'sh7FFF, 16'sh7FFF, 1, 0);
		send_word(REQ_SAMPLE, -16'sd1, 16'sh0000, 1, 0);
		send_word(REQ_TICK, 0, 0, 0, 0);
		send_word(REQ_CLEAR, 0, 0, 0, 0);
		send_word(REQ_TICK, 0, 0, 0, 0);
		drain();

		// pending overflow with no decay and heavy sums
		write_reg(REG_DECAY_COEFF, 24'hFFFFFF);
		for (int i = 0; i < 600; i++)
			send_word(REQ_SAMPLE, 16'sh8000, (i % 2) ? 16'sh8000 : 16'sh7FFF, 1, 0);
		send_word(REQ_TICK, 0, 0, 0, 0);
		drain();

		// zero decay, then enable toggling
		write_reg(REG_DECAY_COEFF, 24'd0);
		random_burst(150, 1);
		drain();
		write_reg(REG_METER_ENABLE, 0);
		random_burst(20, 1);
		drain();
		write_reg(REG_METER_ENABLE, 1);
		write_reg(REG_DECAY_COEFF, DECAY_RESET);
		random_burst(300, 1);
		// pause the sender until every result has come
		drain();
		write_reg(REG_DECAY_COEFF, $urandom_range(0, 24'hFFFFFF));
		rx_quiet = 1;
		random_burst(150, 0);
		rx_quiet = 0;
		random_burst(200, 1);
		drain();

		$display("covered %0d stored samples and %0d ticks, %0d output words checked",
			sb.samples, sb.ticks, sb.words_checked);
		if (sb.errors == 0 && sb.exp_now.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#60000000;
		$display("timeout");
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
